// ===== rtl/core/cau_pkg.sv =====
package cau_pkg;

  // Operation codes.
  localparam logic [1:0] FUNC_ADD = 2'd0;
  localparam logic [1:0] FUNC_MUL = 2'd1;
  localparam logic [1:0] FUNC_NEG = 2'd2;
  localparam logic [1:0] FUNC_RCP = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_DBZ = 2'd2;

  // Pipeline flow control shared by the datapath stages.
  typedef struct packed {
    logic advance;
  } flow_t;

endpackage

// ===== rtl/core/cau_div.sv =====
// Pipelined unsigned restoring divider: one quotient bit per stage.
module cau_div
  import cau_pkg::*;
#(
  parameter int NUM_W = 48,
  parameter int DEN_W = 33
) (
  input  logic             clk,
  input  flow_t            flow,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo
);

  localparam int REM_W = DEN_W + 1;

  logic [NUM_W-1:0] q_st [NUM_W+1];
  logic [NUM_W-1:0] n_st [NUM_W+1];
  logic [REM_W-1:0] r_st [NUM_W+1];
  logic [DEN_W-1:0] d_st [NUM_W+1];

  assign q_st[0] = '0;
  assign n_st[0] = num;
  assign r_st[0] = '0;
  assign d_st[0] = den;

  genvar i;
  generate
    for (i = 0; i < NUM_W; i++) begin : g_step
      logic [REM_W-1:0] shifted;
      logic [REM_W-1:0] diff;
      logic             fits;
      logic [REM_W-1:0] r_q;
      logic [NUM_W-1:0] q_q;
      logic [NUM_W-1:0] n_q;
      logic [DEN_W-1:0] d_q;

      // Shift in the next numerator bit and try a subtraction.
      assign shifted = {r_st[i][REM_W-2:0], n_st[i][NUM_W-1]};
      assign diff    = shifted - {1'b0, d_st[i]};
      assign fits    = shifted >= {1'b0, d_st[i]};

      always_ff @(posedge clk) begin
        if (flow.advance) begin
          r_q <= fits ? diff : shifted;
          q_q <= {q_st[i][NUM_W-2:0], fits};
          n_q <= {n_st[i][NUM_W-2:0], 1'b0};
          d_q <= d_st[i];
        end
      end

      assign r_st[i+1] = r_q;
      assign q_st[i+1] = q_q;
      assign n_st[i+1] = n_q;
      assign d_st[i+1] = d_q;
    end
  endgenerate

  assign quo = q_st[NUM_W];

endmodule

// ===== rtl/core/cau_front.sv =====
// Front stages: products and magnitude squared, then sums and shifts.
module cau_front
  import cau_pkg::*;
#(
  parameter int DW = 16,
  parameter int FB = 8
) (
  input  logic                 clk,
  input  flow_t                flow,
  input  logic [1:0]           func,
  input  logic signed [DW-1:0] a_re,
  input  logic signed [DW-1:0] a_im,
  input  logic signed [DW-1:0] b_re,
  input  logic signed [DW-1:0] b_im,
  output logic [1:0]           f2,
  output logic signed [2*DW+1:0] pre_re,
  output logic signed [2*DW+1:0] pre_im,
  output logic [2*DW:0]        mag,
  output logic [DW:0]          abs_re,
  output logic [DW:0]          abs_im,
  output logic                 neg_re,
  output logic                 neg_im
);

  localparam int PW = 2 * DW + 2;

  // Stage 1: four products and the operands.
  logic [1:0]           f1;
  logic signed [2*DW-1:0] p_rr, p_ii, p_ri, p_ir;
  logic signed [DW-1:0] ar1, ai1, br1, bi1;

  always_ff @(posedge clk) begin
    if (flow.advance) begin
      f1   <= func;
      p_rr <= a_re * b_re;
      p_ii <= a_im * b_im;
      p_ri <= a_re * b_im;
      p_ir <= a_im * b_re;
      ar1  <= a_re;
      ai1  <= a_im;
      br1  <= b_re;
      bi1  <= b_im;
    end
  end

  // Squares for the reciprocal, on a separate register path.
  logic signed [2*DW-1:0] sq_r, sq_i;
  always_ff @(posedge clk) begin
    if (flow.advance) begin
      sq_r <= a_re * a_re;
      sq_i <= a_im * a_im;
    end
  end

  // Stage 2: sums and selection of the pre-saturation result.
  logic signed [PW-1:0] s_re, s_im;
  logic signed [DW:0]   ar_n, ai_n;

  assign ar_n = -{ar1[DW-1], ar1};
  assign ai_n = -{ai1[DW-1], ai1};

  always_comb begin
    s_re = '0;
    s_im = '0;
    case (f1)
      FUNC_ADD: begin
        s_re = PW'(ar1) + PW'(br1);
        s_im = PW'(ai1) + PW'(bi1);
      end
      FUNC_MUL: begin
        s_re = (PW'(p_rr) - PW'(p_ii)) >>> FB;
        s_im = (PW'(p_ri) + PW'(p_ir)) >>> FB;
      end
      FUNC_NEG: begin
        s_re = PW'(ar_n);
        s_im = PW'(ai_n);
      end
      default: begin
        s_re = '0;
        s_im = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (flow.advance) begin
      f2     <= f1;
      pre_re <= s_re;
      pre_im <= s_im;
      mag    <= {1'b0, sq_r} + {1'b0, sq_i};
      // Real part of 1/a follows a_re; imaginary part follows -a_im.
      neg_re <= ar1[DW-1];
      neg_im <= ~ai1[DW-1] && (ai1 != '0);
      abs_re <= ar1[DW-1] ? ar_n : {1'b0, ar1};
      abs_im <= ai1[DW-1] ? ai_n : {1'b0, ai1};
    end
  end

endmodule

// ===== rtl/core/complex_arith_unit.sv =====
// Channel   | Signal group           | Contents
// s_axis    | tvalid/tready/tdata    | request: func, a_re, a_im, b_re, b_im
// m_axis    | tvalid/tready/tdata    | result: res_re, res_im, status
//
// One request enters per cycle while the pipeline is not held; the depth comes
// mostly from the bit-per-stage reciprocal divider that every request traverses.
// rst clears the valid bits of the pipeline and the output register.
// The whole pipeline holds while the output register is full and not taken;
// s_axis_tready is low only then, so nothing is lost or repeated.
module complex_arith_unit
  import cau_pkg::*;
#(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // func, a_re, a_im, b_re, b_im from bit 0 up, zero filled to whole bytes
  input  logic [((2+4*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // res_re, res_im, status from bit 0 up, zero filled to whole bytes
  output logic [((2*DATA_WIDTH+2+7)/8)*8-1:0] m_axis_tdata
);

  localparam int DW     = DATA_WIDTH;
  localparam int FB     = FRAC_BITS;
  localparam int NUM_W  = DW + 2 * FB;
  localparam int DEN_W  = 2 * DW + 1;
  localparam int LAT    = 2 + NUM_W;
  localparam int OUT_W  = ((2 * DW + 2 + 7) / 8) * 8;
  localparam int PW     = 2 * DW + 2;

  flow_t flow;
  logic  out_full;

  assign flow.advance  = !out_full || m_axis_tready;
  assign s_axis_tready = flow.advance;

  // Valid bits travel alongside the data.
  logic [LAT-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (flow.advance) begin
      vld <= {vld[LAT-2:0], s_axis_tvalid};
    end
  end

  // Front stages.
  logic [1:0]           f2;
  logic signed [PW-1:0] pre_re, pre_im;
  logic [2*DW:0]        mag;
  logic [DW:0]          abs_re, abs_im;
  logic                 neg_re, neg_im;

  cau_front #(.DW(DW), .FB(FB)) u_front (
    .clk    (clk),
    .flow   (flow),
    .func   (s_axis_tdata[1:0]),
    .a_re   (s_axis_tdata[2+DW-1:2]),
    .a_im   (s_axis_tdata[2+2*DW-1:2+DW]),
    .b_re   (s_axis_tdata[2+3*DW-1:2+2*DW]),
    .b_im   (s_axis_tdata[2+4*DW-1:2+3*DW]),
    .f2     (f2),
    .pre_re (pre_re),
    .pre_im (pre_im),
    .mag    (mag),
    .abs_re (abs_re),
    .abs_im (abs_im),
    .neg_re (neg_re),
    .neg_im (neg_im)
  );

  // Two divider lanes sharing the magnitude.
  logic [NUM_W-1:0] q_re, q_im;

  cau_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_re (
    .clk (clk), .flow (flow),
    .num (NUM_W'(abs_re) << (2 * FB)),
    .den (mag),
    .quo (q_re)
  );

  cau_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_im (
    .clk (clk), .flow (flow),
    .num (NUM_W'(abs_im) << (2 * FB)),
    .den (mag),
    .quo (q_im)
  );

  // Delay line for the side data matching the divider depth.
  typedef struct packed {
    logic [1:0]           func;
    logic signed [PW-1:0] re;
    logic signed [PW-1:0] im;
    logic                 zero;
    logic                 nre;
    logic                 nim;
  } side_t;

  side_t side [NUM_W+1];
  assign side[0] = '{func: f2, re: pre_re, im: pre_im, zero: (mag == '0),
                     nre: neg_re, nim: neg_im};

  genvar k;
  generate
    for (k = 0; k < NUM_W; k++) begin : g_side
      always_ff @(posedge clk) begin
        if (flow.advance) begin
          side[k+1] <= side[k];
        end
      end
    end
  endgenerate

  // Final stage: select, saturate and encode status.
  side_t                fin;
  logic signed [PW-1:0] v_re, v_im;
  logic signed [PW-1:0] hi_lim, lo_lim;
  logic                 sat_re, sat_im;
  logic [DW-1:0]        r_re, r_im;
  logic [1:0]           st;

  assign fin    = side[NUM_W];
  assign hi_lim = PW'((64'sd1 <<< (DW - 1)) - 1);
  assign lo_lim = -hi_lim - PW'(1);

  always_comb begin
    v_re = fin.re;
    v_im = fin.im;
    if (fin.func == FUNC_RCP) begin
      if (fin.zero) begin
        v_re = '0;
        v_im = '0;
      end else begin
        v_re = fin.nre ? -PW'(q_re) : PW'(q_re);
        v_im = fin.nim ? -PW'(q_im) : PW'(q_im);
      end
    end
    sat_re = (v_re > hi_lim) || (v_re < lo_lim);
    sat_im = (v_im > hi_lim) || (v_im < lo_lim);
    r_re = (v_re > hi_lim) ? hi_lim[DW-1:0] :
           (v_re < lo_lim) ? lo_lim[DW-1:0] : v_re[DW-1:0];
    r_im = (v_im > hi_lim) ? hi_lim[DW-1:0] :
           (v_im < lo_lim) ? lo_lim[DW-1:0] : v_im[DW-1:0];
    if (fin.func == FUNC_RCP && fin.zero) begin
      st = ST_DBZ;
    end else if (sat_re || sat_im) begin
      st = ST_SAT;
    end else begin
      st = ST_OK;
    end
  end

  // Output register.
  logic [OUT_W-1:0] out_data;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (flow.advance) begin
      out_full <= vld[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (flow.advance) begin
      out_data <= OUT_W'({st, r_im, r_re});
    end
  end

  assign m_axis_tvalid = out_full;
  assign m_axis_tdata  = out_data;

`ifndef SYNTH
  // A held result keeps its data until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // A stall freezes the pipeline valid bits.
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |=> $stable(vld))
    else $error("pipeline moved during stall");

  // Status never carries an unused code.
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[2*DW+1:2*DW] != 2'd3))
    else $error("bad status code");
`endif

endmodule
